[src/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants for the packed bit record store
// Field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int OP_W      = 1;
    localparam int STATE_W   = 8;
    localparam int INDEX_W   = 15;
    localparam int LEN_W     = 7;
    localparam int MASK_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int RECORD_W  = 64;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // bit address of a record start: index times length
    localparam int START_W   = INDEX_W + LEN_W;
    // word address taken from a bit address
    localparam int WIDX_W    = START_W - 5;
    // bit position compares carry one extra bit
    localparam int POS_W     = START_W + 1;
    // three words cover any record of up to 64 bits at any offset
    localparam int WIN_W     = 3 * WORD_W;

    localparam logic [OP_W-1:0] OP_APPEND = 1'b0;
    localparam logic [OP_W-1:0] OP_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_MASK       = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAST_END = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_EXTRACT
    } prs_state_t;

endpackage

[src/prs_ram.sv]
// ----------------------------------------------------------------------------
// prs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/packed_bit_record_store.sv]
// ----------------------------------------------------------------------------
// packed_bit_record_store: single-bit record store packed into 32-bit words
// Append: result registered at the transfer edge; one per cycle while out_ready holds.
// Read: multiply, check + first fetch, three fetch slots, extract.
// Reset (rst_n, async low) clears counts and partial word, resets config; no RAM pass.
// ----------------------------------------------------------------------------
module packed_bit_record_store #(
    parameter int STORE_WORDS = 1024,
    parameter int MAX_RECORD  = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write_en,
    input  logic [prs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prs_pkg::CFG_DAT_W-1:0]  cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [prs_pkg::OP_W-1:0]       op,
    input  logic [prs_pkg::STATE_W-1:0]    element_state,
    input  logic [prs_pkg::INDEX_W-1:0]    record_index,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [prs_pkg::STATUS_W-1:0]   status,
    output logic [prs_pkg::RECORD_W-1:0]   record_bits
);

    import prs_pkg::*;

    // Word store address and fill count widths. The fill count must hold
    // STORE_WORDS itself, so it is one bit wider than the address at powers
    // of two.
    localparam int AW = $clog2(STORE_WORDS);
    localparam int FW = $clog2(STORE_WORDS + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    prs_state_t            state_reg, state_next;
    logic [1:0]            fcnt_reg, fcnt_next;

    logic [LEN_W-1:0]      record_length_reg;
    logic [MASK_W-1:0]     on_mask_reg;

    logic [WORD_W-1:0]     partial_word_reg, partial_word_next;
    logic [4:0]            partial_count_reg, partial_count_next;
    logic [FW-1:0]         full_words_reg, full_words_next;

    // read datapath
    logic [START_W-1:0]    start_reg, start_next;
    logic                  sel_partial_reg, sel_partial_next;
    logic [WIN_W-1:0]      window_reg, window_next;

    // output register; it parts the two channels
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [RECORD_W-1:0]   record_bits_reg, record_bits_next;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]      len;
    logic                  store_full;
    logic                  new_bit;
    logic [WORD_W-1:0]     shifted_word;
    logic [POS_W-1:0]      total_bits;
    logic [POS_W-1:0]      end_pos;
    logic [WIDX_W-1:0]     base_word;
    logic [WIDX_W-1:0]     fetch_word;
    logic [5:0]            align_amt;
    logic [WORD_W-1:0]     partial_aligned;
    logic [WIN_W-1:0]      window_rev;
    logic [WIN_W-1:0]      window_shr;
    logic [RECORD_W-1:0]   len_mask;
    logic                  in_xfer;

    // lengths above the build limit saturate
    assign len = (record_length_reg > LEN_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                           : record_length_reg;

    assign store_full   = (full_words_reg == FW'(STORE_WORDS));
    assign new_bit      = |(element_state & on_mask_reg);
    assign shifted_word = {partial_word_reg[WORD_W-2:0], new_bit};

    // appended bits so far: 32 per full word plus the partial count
    assign total_bits = POS_W'({full_words_reg, partial_count_reg});
    assign end_pos    = {1'b0, start_reg} + POS_W'(len);

    assign base_word  = start_reg[START_W-1:5];
    assign fetch_word = base_word + WIDX_W'(fcnt_reg);

    // The partial word holds its oldest bit at partial_count-1. Shifting it
    // to the top makes it look like a stored word, oldest bit at bit 31.
    // An empty partial word shifts by 32 and reads as zero.
    assign align_amt       = 6'd32 - {1'b0, partial_count_reg};
    assign partial_aligned = partial_word_reg << align_amt;

    // Window holds three words, first at the top. Reversing it puts stream
    // position p at bit p, so the record is a right shift by the offset.
    always_comb
    begin
        for (int i = 0; i < WIN_W; i++)
        begin
            window_rev[i] = window_reg[WIN_W-1-i];
        end
    end

    assign window_shr = window_rev >> start_reg[4:0];
    assign len_mask   = ~({RECORD_W{1'b1}} << len);

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        fcnt_next          = fcnt_reg;
        partial_word_next  = partial_word_reg;
        partial_count_next = partial_count_reg;
        full_words_next    = full_words_reg;
        start_next         = start_reg;
        sel_partial_next   = sel_partial_reg;
        window_next        = window_reg;
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        record_bits_next   = record_bits_reg;

        ram_we    = 1'b0;
        ram_waddr = full_words_reg[AW-1:0];
        ram_wdata = shifted_word;
        ram_raddr = fetch_word[AW-1:0];

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (op == OP_APPEND)
                    begin
                        // appends finish in the transfer cycle
                        out_valid_next   = 1'b1;
                        record_bits_next = '0;
                        if (store_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            if (partial_count_reg == 5'd31)
                            begin
                                // word complete: commit to RAM
                                ram_we             = 1'b1;
                                full_words_next    = full_words_reg + FW'(1);
                                partial_word_next  = '0;
                                partial_count_next = '0;
                            end
                            else
                            begin
                                partial_word_next  = shifted_word;
                                partial_count_next = partial_count_reg + 5'd1;
                            end
                        end
                    end
                    else
                    begin
                        // record start bit; registered before any use
                        start_next = START_W'(record_index) * START_W'(len);
                        fcnt_next  = 2'd0;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (end_pos > total_bits)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = ST_PAST_END;
                    record_bits_next = '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    // first word address goes out now (fcnt is zero)
                    sel_partial_next = (fetch_word >= WIDX_W'(full_words_reg));
                    fcnt_next        = 2'd1;
                    state_next       = S_FETCH;
                end
            end

            S_FETCH:
            begin
                // take the word addressed last cycle
                window_next = {window_reg[WIN_W-WORD_W-1:0],
                               sel_partial_reg ? partial_aligned : ram_rdata};
                if (fcnt_reg == 2'd3)
                begin
                    state_next = S_EXTRACT;
                end
                else
                begin
                    sel_partial_next = (fetch_word >= WIDX_W'(full_words_reg));
                    fcnt_next        = fcnt_reg + 2'd1;
                end
            end

            S_EXTRACT:
            begin
                out_valid_next   = 1'b1;
                status_next      = ST_OK;
                record_bits_next = window_shr[RECORD_W-1:0] & len_mask;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            fcnt_reg          <= '0;
            partial_word_reg  <= '0;
            partial_count_reg <= '0;
            full_words_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            fcnt_reg          <= fcnt_next;
            partial_word_reg  <= partial_word_next;
            partial_count_reg <= partial_count_next;
            full_words_reg    <= full_words_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_length_reg <= LEN_W'(1);
            on_mask_reg       <= MASK_W'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_RECORD_LENGTH: record_length_reg <= cfg_data[LEN_W-1:0];
                CFG_ON_MASK:       on_mask_reg       <= cfg_data[MASK_W-1:0];
                default:           ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        start_reg       <= start_next;
        sel_partial_reg <= sel_partial_next;
        window_reg      <= window_next;
        status_reg      <= status_next;
        record_bits_reg <= record_bits_next;
    end

    // ------------------------------------------------------------------
    // Word store
    // ------------------------------------------------------------------
    prs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_word_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign record_bits = record_bits_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (op == OP_APPEND) && store_full)
        |=> (out_valid_reg && (status_reg == ST_FULL) && $stable(full_words_reg)))
        else $error("append to full store not flagged or changed fill count");

    a_busy_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE)
        |=> ($stable(partial_count_reg) && $stable(full_words_reg)))
        else $error("store contents moved during a read");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        full_words_reg <= FW'(STORE_WORDS))
        else $error("fill count beyond store depth");

    a_past_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (record_bits_reg == '0))
        else $error("rejected item carries record bits");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for packed_bit_record_store
// Directed table first, then random append/read traffic over several register
// settings and handshake idling patterns. Every result transfer is checked
// against a table value or a local predictor of the packed store.
// ----------------------------------------------------------------------------
module tb;
    import prs_pkg::*;

    localparam int STORE_WORDS = 1024;
    localparam int MAX_RECORD  = 64;
    // generous ceiling for about 2k items, even with the heaviest idling
    localparam int CYCLE_LIMIT = 250_000;
    // quiet cycles after the last result, well over the read latency
    localparam int END_GUARD   = 32;
    localparam int PHASE_ITEMS = 250;

    // handshake idling modes: none, sender idle, receiver stall, both
    localparam int SEND_IDLE  [4] = '{0, 81, 0, 30};
    localparam int RECV_STALL [4] = '{0, 0, 81, 30};

    // register settings for the random phases; the last two phases are random
    localparam logic [CFG_DAT_W-1:0] PHASE_LEN  [6] = '{8'd1, 8'd64, 8'd0, 8'hFF, 8'd33, 8'd32};
    localparam logic [CFG_DAT_W-1:0] PHASE_MASK [6] = '{8'h01, 8'hFF, 8'h00, 8'h80, 8'h5A, 8'h24};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RECORD_W-1:0] record_bits;
    } store_result_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // one directed row: an item transfer or a register write
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  cfg_sel;
        logic [OP_W-1:0]       op;
        logic [STATE_W-1:0]    data;     // element_state, or register value
        logic [INDEX_W-1:0]    idx;
        bit                    typed;    // expected result given in the row
        logic [STATUS_W-1:0]   status;
        logic [RECORD_W-1:0]   record_bits;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    // after reset: record_length 1, on_mask 1
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty store: any read is past the end
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd0,     1'b1, ST_PAST_END, 64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'h01, 15'h7FFF,  1'b1, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'hFE, 15'd0,     1'b1, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'hFF, 15'd0,     1'b1, ST_OK,       64'd1},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd1,     1'b1, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd2,     1'b1, ST_PAST_END, 64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'h7FFF,  1'b1, ST_PAST_END, 64'd0},
        '{ROW_CFG,  CFG_ON_MASK,       OP_APPEND, 8'hFF, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'h80, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'h00, 15'd0,     1'b0, ST_OK,       64'd0},
        // stored so far, oldest first: 1 0 1 0
        '{ROW_CFG,  CFG_RECORD_LENGTH, OP_APPEND, 8'd4,  15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd0,     1'b1, ST_OK,       64'h5},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd1,     1'b1, ST_PAST_END, 64'd0},
        // zero length: empty record, always in range
        '{ROW_CFG,  CFG_RECORD_LENGTH, OP_APPEND, 8'd0,  15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'h7FFF,  1'b1, ST_OK,       64'd0},
        // 127 saturates to 64, far more than has been appended
        '{ROW_CFG,  CFG_RECORD_LENGTH, OP_APPEND, 8'hFF, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd0,     1'b1, ST_PAST_END, 64'd0},
        '{ROW_CFG,  CFG_ON_MASK,       OP_APPEND, 8'h00, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'hFF, 15'd0,     1'b1, ST_OK,       64'd0},
        // five bits now: 1 0 1 0 0
        '{ROW_CFG,  CFG_RECORD_LENGTH, OP_APPEND, 8'd2,  15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd2,     1'b1, ST_PAST_END, 64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd1,     1'b1, ST_OK,       64'd1},
        '{ROW_CFG,  CFG_ON_MASK,       OP_APPEND, 8'h80, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'h7F, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_APPEND, 8'h80, 15'd0,     1'b0, ST_OK,       64'd0},
        '{ROW_ITEM, CFG_RECORD_LENGTH, OP_READ,   8'h00, 15'd2,     1'b0, ST_OK,       64'd0}
    };

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_write_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DAT_W-1:0]  cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       op            = OP_APPEND;
    logic [STATE_W-1:0]    element_state = '0;
    logic [INDEX_W-1:0]    record_index  = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [RECORD_W-1:0]   record_bits;

    packed_bit_record_store #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_RECORD  (MAX_RECORD)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .element_state (element_state),
        .record_index  (record_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .record_bits   (record_bits)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: own copy of the packed store and the registers
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]  model_words [STORE_WORDS];
    logic [WORD_W-1:0]  model_partial = '0;
    int unsigned        model_pcount  = 0;
    int unsigned        model_full    = 0;
    logic [LEN_W-1:0]   model_len     = 7'd1;
    logic [MASK_W-1:0]  model_mask    = 8'h01;

    store_result_t      awaited_results [$];
    int                 mismatch_count = 0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int unsigned        cycle_count    = 0;

    function automatic int unsigned record_span();
        return (model_len > MAX_RECORD) ? MAX_RECORD : int'(model_len);
    endfunction

    function automatic longint unsigned appended_bits();
        return 64'(model_full) * WORD_W + model_pcount;
    endfunction

    // bit at append position pos; oldest bit of a word sits at its MSB
    function automatic logic stored_bit(longint unsigned pos);
        longint unsigned w;
        int unsigned     off;
        w   = pos / WORD_W;
        off = int'(pos % WORD_W);
        if (w < model_full)
            return model_words[w][WORD_W-1-off];
        if (off < model_pcount)
            return model_partial[model_pcount-1-off];
        return 1'b0;
    endfunction

    // result of one accepted item; appends also advance the store
    function automatic store_result_t store_outcome(logic [OP_W-1:0] o,
                                                    logic [STATE_W-1:0] s,
                                                    logic [INDEX_W-1:0] i);
        store_result_t   r;
        int unsigned     span;
        longint unsigned first;
        r = '0;
        if (o == OP_APPEND) begin
            if (model_full >= STORE_WORDS) begin
                r.status = ST_FULL;
            end
            else begin
                model_partial = {model_partial[WORD_W-2:0], |(s & model_mask)};
                model_pcount++;
                if (model_pcount == WORD_W) begin
                    model_words[model_full] = model_partial;
                    model_full++;
                    model_partial = '0;
                    model_pcount  = 0;
                end
            end
        end
        else begin
            span  = record_span();
            first = 64'(i) * span;
            if (first + span > appended_bits())
                r.status = ST_PAST_END;
            else
                for (int k = 0; k < span; k++)
                    r.record_bits[k] = stored_bit(first + k);
        end
        return r;
    endfunction

    // mostly records that exist, some just past the end, some anywhere
    function automatic logic [INDEX_W-1:0] pick_index();
        int unsigned     span;
        longint unsigned count;
        span = record_span();
        if (span == 0 || $urandom_range(9) == 0)
            return INDEX_W'($urandom);
        count = appended_bits() / span;
        if (count == 0)
            return INDEX_W'($urandom_range(2));
        if (count > 32768)
            count = 32768;
        if ($urandom_range(4) == 0)
            return INDEX_W'(count);
        return INDEX_W'($urandom_range(int'(count) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // One input transfer. valid is only dropped when a gap is taken, so a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic send_item(input logic [OP_W-1:0] o, input logic [STATE_W-1:0] s,
                             input logic [INDEX_W-1:0] i, input bit typed = 1'b0,
                             input store_result_t want = '0);
        store_result_t predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        op            <= o;
        element_state <= s;
        record_index  <= i;
        do @(posedge clk); while (!in_ready);
        // transfer taken at this edge
        predicted = store_outcome(o, s, i);
        awaited_results.insert(awaited_results.size(), typed ? want : predicted);
    endtask

    task automatic random_item(input int append_pct);
        if ($urandom_range(99) < append_pct)
            send_item(OP_APPEND, STATE_W'($urandom), INDEX_W'($urandom));
        else
            send_item(OP_READ, STATE_W'($urandom), pick_index());
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= sel;
        cfg_data     <= val;
        @(posedge clk);
        if (sel == CFG_RECORD_LENGTH)
            model_len = val[LEN_W-1:0];
        else
            model_mask = val[MASK_W-1:0];
        cfg_write_en <= 1'b0;
    endtask

    // both registers back to back, enable held across the pair
    task automatic set_config(input logic [CFG_DAT_W-1:0] len_val,
                              input logic [CFG_DAT_W-1:0] mask_val);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_RECORD_LENGTH;
        cfg_data     <= len_val;
        @(posedge clk);
        model_len  = len_val[LEN_W-1:0];
        cfg_index <= CFG_ON_MASK;
        cfg_data  <= mask_val;
        @(posedge clk);
        model_mask    = mask_val;
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct  = SEND_IDLE[mode];
        recv_stall_pct = RECV_STALL[mode];
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stall, and the check of each result transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        store_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result transfer with none awaited: status %0d, record_bits %h",
                       status, record_bits);
                mismatch_count++;
            end
            else begin
                want = awaited_results.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
                if (record_bits !== want.record_bits) begin
                    $error("record_bits: expected %h, got %h",
                           want.record_bits, record_bits);
                    mismatch_count++;
                end
            end
        end
    end

    // run ceiling
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        stim_row_t row;
        logic [CFG_DAT_W-1:0] len_val;
        logic [CFG_DAT_W-1:0] mask_val;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, with light idling on both sides
        set_idling(3);
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                drain();
                write_reg(row.cfg_sel, row.data);
            end
            else begin
                send_item(row.op, row.data, row.idx, row.typed,
                          '{status: row.status, record_bits: row.record_bits});
            end
        end

        // random phases, one register setting and one idling mode each;
        // halfway through each phase the sender waits for a full drain
        for (int p = 0; p < 8; p++) begin
            drain();
            len_val  = (p < 6) ? PHASE_LEN[p]  : CFG_DAT_W'($urandom);
            mask_val = (p < 6) ? PHASE_MASK[p] : CFG_DAT_W'($urandom);
            set_config(len_val, mask_val);
            set_idling(p % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                random_item(55);
            end
        end

        drain();
        // anything arriving now is an unexpected result
        repeat (END_GUARD) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
